[hw/rtl/assert_macros.svh]
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/grs_pkg.sv]
// package: types, constants and codes of the graph search block
`default_nettype none
package grs_pkg;
  localparam int unsigned NodeCountDef = 64;
  localparam int unsigned MaxDegreeDef = 8;
  localparam int unsigned NodeW = 6;
  localparam int unsigned OpW = 2;
  localparam int unsigned StatusW = 3;
  localparam int unsigned ExplW = 7;

  localparam logic [OpW-1:0] OP_ADD = 2'd0;
  localparam logic [OpW-1:0] OP_DFS = 2'd1;
  localparam logic [OpW-1:0] OP_BFS = 2'd2;
  // also runs breadth-first
  localparam logic [OpW-1:0] OP_BFS_ALT = 2'd3;

  localparam logic [StatusW-1:0] ST_ADDED = 3'd0;
  localparam logic [StatusW-1:0] ST_EXISTED = 3'd1;
  localparam logic [StatusW-1:0] ST_FULL = 3'd2;
  localparam logic [StatusW-1:0] ST_FOUND = 3'd3;
  localparam logic [StatusW-1:0] ST_MISSING = 3'd4;
  localparam logic [StatusW-1:0] ST_UNREACH = 3'd5;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture request
    logic deg_cap;    // register origin out-degree
    logic clr_start;  // start visited clear sweep
    logic clr_step;   // clear one visited entry
    logic deg_clr;    // clear one out-degree entry
    logic init;       // mark start visited, push start
    logic pop;        // pop frontier
    logic pop_rd;     // register popped node, read its out-degree
    logic nb_start;   // register out-degree, reset neighbor index
    logic nb_rd;      // issue adjacency read
    logic nb_eval;    // check neighbor against target, read visited
    logic nb_vis;     // mark and push neighbor
    logic chk_rd;     // add-edge: read entry
    logic chk_eval;   // add-edge: compare entry
    logic append;     // write new edge
  } grs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_add;
    logic src_range_ok;
    logic dst_range_ok;
    logic src_exists;
    logic src_eq_dst;
    logic deg_full;
    logic clr_done;
    logic front_empty;
    logic nb_done;
    logic hit;
    logic chk_done;
    logic chk_match;
  } grs_stat_t;
endpackage
`default_nettype wire

[hw/rtl/grs_ram.sv]
// generic single port write, single read port ram with registered read
`default_nettype none
module grs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[hw/rtl/grs_datapath.sv]
// datapath: graph store, visited map, frontier and counters
`default_nettype none
module grs_datapath #(
  parameter int unsigned NodeCount = 64,
  parameter int unsigned MaxDegree = 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire grs_pkg::grs_cmd_t      cmd_i,
  input  wire logic [grs_pkg::OpW-1:0]   opcode_i,
  input  wire logic [grs_pkg::NodeW-1:0] src_node_i,
  input  wire logic [grs_pkg::NodeW-1:0] dst_node_i,
  output grs_pkg::grs_stat_t          stat_o,
  output logic [grs_pkg::ExplW-1:0]   explored_o
);
  import grs_pkg::*;

  localparam int unsigned IdxW = (NodeCount > 1) ? $clog2(NodeCount) : 1;
  localparam int unsigned DegW = $clog2(MaxDegree + 1);
  localparam int unsigned AdjAw = $clog2(NodeCount * MaxDegree);
  localparam int unsigned FtW = $clog2(NodeCount + 1);

  logic [OpW-1:0]   op_q;
  logic [NodeW-1:0] src_q, dst_q;
  logic [DegW-1:0]  src_deg_q;
  logic [IdxW:0]    clr_q;
  logic [FtW-1:0]   head_q, tail_q;
  logic [ExplW-1:0] cnt_q;
  logic [NodeW-1:0] node_q;
  logic [NodeW-1:0] nb_q;
  logic [DegW-1:0]  ndeg_q;
  logic [DegW-1:0]  k_q;
  logic             hit_q;

  logic [NodeW-1:0] adj_rdata, fr_rdata;
  logic             adj_we, fr_we;
  logic [AdjAw-1:0] adj_waddr, adj_raddr;
  logic [NodeW-1:0] adj_wdata, fr_wdata;
  logic [IdxW-1:0]  fr_waddr, fr_raddr;
  logic             deg_we;
  logic [IdxW-1:0]  deg_waddr, deg_raddr;
  logic [DegW-1:0]  deg_wdata, deg_rdata;
  logic             vis_we;
  logic [IdxW-1:0]  vis_waddr, vis_raddr;
  logic             vis_wdata, vis_rdata;
  logic [IdxW-1:0]  src_idx, node_idx, clr_idx;
  logic             lifo;
  logic             push_ok;
  logic [FtW-1:0]   pop_pos;

  assign lifo = (op_q == OP_DFS);
  assign src_idx = src_q[IdxW-1:0];
  assign node_idx = node_q[IdxW-1:0];
  assign clr_idx = clr_q[IdxW-1:0];
  assign pop_pos = lifo ? tail_q - FtW'(1) : head_q;
  assign push_ok = cmd_i.nb_vis && !hit_q && (32'(nb_q) < NodeCount) && !vis_rdata
                   && (32'(tail_q) < NodeCount);

  // adjacency memory address: node * degree + k
  always_comb begin
    adj_we = cmd_i.append;
    adj_waddr = AdjAw'(src_idx * MaxDegree) + AdjAw'(src_deg_q);
    adj_wdata = dst_q;
    if (cmd_i.chk_rd) begin
      adj_raddr = AdjAw'(src_idx * MaxDegree) + AdjAw'(k_q);
    end else begin
      adj_raddr = AdjAw'(node_idx * MaxDegree) + AdjAw'(k_q);
    end
  end

  always_comb begin
    deg_we = cmd_i.deg_clr || cmd_i.append;
    deg_waddr = cmd_i.deg_clr ? clr_idx : src_idx;
    deg_wdata = cmd_i.deg_clr ? '0 : src_deg_q + DegW'(1);
    deg_raddr = cmd_i.pop_rd ? fr_rdata[IdxW-1:0] : src_idx;
  end

  always_comb begin
    vis_we = 1'b0;
    vis_waddr = clr_idx;
    vis_wdata = 1'b0;
    if (cmd_i.clr_step) begin
      vis_we = 1'b1;
    end else if (cmd_i.init) begin
      vis_we = 1'b1;
      vis_waddr = src_idx;
      vis_wdata = 1'b1;
    end else if (push_ok) begin
      vis_we = 1'b1;
      vis_waddr = nb_q[IdxW-1:0];
      vis_wdata = 1'b1;
    end
    vis_raddr = adj_rdata[IdxW-1:0];
  end

  always_comb begin
    fr_we = 1'b0;
    fr_waddr = tail_q[IdxW-1:0];
    fr_wdata = nb_q;
    if (cmd_i.init) begin
      fr_we = 1'b1;
      fr_waddr = '0;
      fr_wdata = src_q;
    end else if (push_ok) begin
      fr_we = 1'b1;
    end
    fr_raddr = pop_pos[IdxW-1:0];
  end

  grs_ram #(.Width(NodeW), .Depth(NodeCount * MaxDegree)) u_adj (
    .clk_i(clk_i), .we_i(adj_we), .waddr_i(adj_waddr), .wdata_i(adj_wdata),
    .raddr_i(adj_raddr), .rdata_o(adj_rdata)
  );

  grs_ram #(.Width(NodeW), .Depth(NodeCount)) u_front (
    .clk_i(clk_i), .we_i(fr_we), .waddr_i(fr_waddr), .wdata_i(fr_wdata),
    .raddr_i(fr_raddr), .rdata_o(fr_rdata)
  );

  grs_ram #(.Width(DegW), .Depth(NodeCount)) u_deg (
    .clk_i(clk_i), .we_i(deg_we), .waddr_i(deg_waddr), .wdata_i(deg_wdata),
    .raddr_i(deg_raddr), .rdata_o(deg_rdata)
  );

  grs_ram #(.Width(1), .Depth(NodeCount)) u_vis (
    .clk_i(clk_i), .we_i(vis_we), .waddr_i(vis_waddr), .wdata_i(vis_wdata),
    .raddr_i(vis_raddr), .rdata_o(vis_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_deg_q <= '0;
      clr_q <= '0;
      head_q <= '0;
      tail_q <= '0;
      cnt_q <= '0;
      k_q <= '0;
      hit_q <= 1'b0;
      op_q <= '0;
      src_q <= '0;
      dst_q <= '0;
      node_q <= '0;
      nb_q <= '0;
      ndeg_q <= '0;
    end else begin
      if (cmd_i.load) begin
        op_q <= opcode_i;
        src_q <= src_node_i;
        dst_q <= dst_node_i;
        k_q <= '0;
        hit_q <= 1'b0;
        cnt_q <= '0;
      end
      if (cmd_i.deg_cap) src_deg_q <= deg_rdata;
      if (cmd_i.clr_start) clr_q <= '0;
      if (cmd_i.clr_step) clr_q <= clr_q + 1'b1;
      if (cmd_i.init) begin
        head_q <= '0;
        tail_q <= FtW'(1);
        cnt_q <= '0;
      end
      if (cmd_i.pop) begin
        if (lifo) tail_q <= tail_q - FtW'(1);
        else head_q <= head_q + FtW'(1);
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.pop_rd) node_q <= fr_rdata;
      if (cmd_i.nb_start) begin
        k_q <= '0;
        ndeg_q <= (32'(node_q) < NodeCount) ? deg_rdata : '0;
      end
      if (cmd_i.nb_rd) k_q <= k_q + 1'b1;
      if (cmd_i.nb_eval) begin
        nb_q <= adj_rdata;
        if (adj_rdata == dst_q) hit_q <= 1'b1;
      end
      if (push_ok) tail_q <= tail_q + FtW'(1);
      if (cmd_i.chk_rd) k_q <= k_q + 1'b1;
      if (cmd_i.chk_eval && adj_rdata == dst_q) hit_q <= 1'b1;
    end
  end

  always_comb begin
    stat_o.is_add = (op_q == OP_ADD);
    stat_o.src_range_ok = (32'(src_q) < NodeCount);
    stat_o.dst_range_ok = (32'(dst_q) < NodeCount);
    stat_o.src_exists = stat_o.src_range_ok && (deg_rdata != '0);
    stat_o.src_eq_dst = (src_q == dst_q);
    stat_o.deg_full = stat_o.src_range_ok && (32'(src_deg_q) >= MaxDegree);
    stat_o.clr_done = (32'(clr_q) >= NodeCount);
    stat_o.front_empty = !(head_q < tail_q);
    stat_o.nb_done = (k_q >= ndeg_q);
    stat_o.hit = hit_q;
    stat_o.chk_done = stat_o.src_range_ok ? (k_q >= src_deg_q) : 1'b1;
    stat_o.chk_match = hit_q;
  end

  assign explored_o = cnt_q;
endmodule
`default_nettype wire

[hw/rtl/grs_ctrl.sv]
// controller: sequences add-edge and search requests
`default_nettype none
module grs_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  input  wire grs_pkg::grs_stat_t     stat_i,
  input  wire logic [grs_pkg::ExplW-1:0] cnt_i,
  output grs_pkg::grs_cmd_t           cmd_o,
  output logic [grs_pkg::StatusW-1:0] status_o,
  output logic [grs_pkg::ExplW-1:0]   explored_o
);
  import grs_pkg::*;

  typedef enum logic [3:0] {
    S_BOOT, S_IDLE, S_SRC_RD, S_DECIDE, S_CHK_RD, S_CHK_EVAL, S_CLEAR, S_INIT, S_POP,
    S_POP_RD, S_NB_LD, S_NB_RD, S_NB_EVAL, S_NB_VIS, S_DONE
  } state_e;

  state_e state_q;
  logic   busy;

  assign busy = (state_q != S_IDLE) || (out_valid_o && out_stall_i);
  assign in_stall_o = busy;

  always_comb begin
    cmd_o = '0;
    cmd_o.load = (state_q == S_IDLE) && in_valid_i && !busy;
    unique case (state_q)
      S_BOOT: begin
        cmd_o.clr_step = !stat_i.clr_done;
        cmd_o.deg_clr = !stat_i.clr_done;
      end
      S_DECIDE: begin
        cmd_o.clr_start = !stat_i.is_add;
        cmd_o.deg_cap = 1'b1;
      end
      S_CHK_RD: cmd_o.chk_rd = !stat_i.chk_done;
      S_CHK_EVAL: cmd_o.chk_eval = 1'b1;
      S_CLEAR: cmd_o.clr_step = !stat_i.clr_done;
      S_INIT: cmd_o.init = 1'b1;
      S_POP: cmd_o.pop = !stat_i.front_empty;
      S_POP_RD: cmd_o.pop_rd = 1'b1;
      S_NB_LD: cmd_o.nb_start = 1'b1;
      S_NB_RD: cmd_o.nb_rd = !stat_i.nb_done;
      S_NB_EVAL: cmd_o.nb_eval = 1'b1;
      S_NB_VIS: cmd_o.nb_vis = 1'b1;
      S_DONE: cmd_o.append = stat_i.is_add && stat_i.src_range_ok && stat_i.dst_range_ok
                             && !stat_i.chk_match && !stat_i.deg_full;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_BOOT;
      out_valid_o <= 1'b0;
      status_o <= ST_ADDED;
      explored_o <= '0;
    end else begin
      if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
      unique case (state_q)
        S_BOOT: if (stat_i.clr_done) state_q <= S_IDLE;
        S_IDLE: if (cmd_o.load) state_q <= S_SRC_RD;
        S_SRC_RD: state_q <= S_DECIDE;
        S_DECIDE: begin
          if (stat_i.is_add) begin
            state_q <= S_CHK_RD;
          end else if (!stat_i.src_exists) begin
            status_o <= ST_MISSING;
            explored_o <= '0;
            state_q <= S_DONE;
          end else if (stat_i.src_eq_dst) begin
            status_o <= ST_FOUND;
            explored_o <= ExplW'(1);
            state_q <= S_DONE;
          end else begin
            state_q <= S_CLEAR;
          end
        end
        S_CHK_RD: begin
          if (stat_i.chk_done || stat_i.chk_match) begin
            explored_o <= '0;
            if (!stat_i.src_range_ok || !stat_i.dst_range_ok) status_o <= ST_FULL;
            else if (stat_i.chk_match) status_o <= ST_EXISTED;
            else if (stat_i.deg_full) status_o <= ST_FULL;
            else status_o <= ST_ADDED;
            state_q <= S_DONE;
          end else begin
            state_q <= S_CHK_EVAL;
          end
        end
        S_CHK_EVAL: state_q <= S_CHK_RD;
        S_CLEAR: if (stat_i.clr_done) state_q <= S_INIT;
        S_INIT: state_q <= S_POP;
        S_POP: begin
          if (stat_i.front_empty) begin
            status_o <= ST_UNREACH;
            explored_o <= '0;
            state_q <= S_DONE;
          end else begin
            state_q <= S_POP_RD;
          end
        end
        S_POP_RD: state_q <= S_NB_LD;
        S_NB_LD: state_q <= S_NB_RD;
        S_NB_RD: begin
          if (stat_i.hit) begin
            status_o <= ST_FOUND;
            explored_o <= cnt_i;
            state_q <= S_DONE;
          end else if (stat_i.nb_done) begin
            state_q <= S_POP;
          end else begin
            state_q <= S_NB_EVAL;
          end
        end
        S_NB_EVAL: state_q <= S_NB_VIS;
        S_NB_VIS: state_q <= S_NB_RD;
        S_DONE: begin
          out_valid_o <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[hw/rtl/graph_reachability_search.sv]
// top level: directed graph store with depth-first and breadth-first search
// add-edge request: the source list is read and compared entry by entry, one request at a time
// search request: a visited clear sweep, then states POP, POP_RD, NB_LD and NB_RD per pop
// and NB_EVAL, NB_VIS and NB_RD per adjacency entry read (single read port rams)
// reset: a clearing pass empties all lists, input stalled meanwhile
`default_nettype none
module graph_reachability_search
  import grs_pkg::*;
#(
  parameter int unsigned NodeCount = grs_pkg::NodeCountDef,
  parameter int unsigned MaxDegree = grs_pkg::MaxDegreeDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [grs_pkg::OpW-1:0]       opcode_i,
  input  wire logic [grs_pkg::NodeW-1:0]     src_node_i,
  input  wire logic [grs_pkg::NodeW-1:0]     dst_node_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [grs_pkg::StatusW-1:0]        status_o,
  output logic [grs_pkg::ExplW-1:0]          explored_o
);
`include "assert_macros.svh"

  grs_cmd_t cmd;
  grs_stat_t stat;
  logic [ExplW-1:0] cnt;

  grs_datapath #(.NodeCount(NodeCount), .MaxDegree(MaxDegree)) u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(cmd), .opcode_i(opcode_i),
    .src_node_i(src_node_i), .dst_node_i(dst_node_i), .stat_o(stat), .explored_o(cnt)
  );

  grs_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .stat_i(stat), .cnt_i(cnt),
    .cmd_o(cmd), .status_o(status_o), .explored_o(explored_o)
  );

  `ASSERT_IMPL(a_explored_zero, clk_i, rst_ni, out_valid_o && status_o != ST_FOUND,
               explored_o == '0)
  `ASSERT_IMPL(a_no_accept_busy, clk_i, rst_ni, out_valid_o && out_stall_i, in_stall_o)
  `ASSERT_NEXT(a_accept_blocks, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
endmodule
`default_nettype wire
